### hdl/f16od_pkg.sv
// ----------------------------------------------------------------------------
// f16od_pkg
// Shared types, operation codes and the combinational decode function of the
// fixed 16-bit opcode decoder.
// ----------------------------------------------------------------------------
package f16od_pkg;

	// Operation family numbers.
	localparam logic [5:0] OP_ADDI       = 6'd0;
	localparam logic [5:0] OP_MOVREGDISP = 6'd1;
	localparam logic [5:0] OP_CMP        = 6'd2;
	localparam logic [5:0] OP_BT         = 6'd3;
	localparam logic [5:0] OP_MOVI       = 6'd4;
	localparam logic [5:0] OP_BRA        = 6'd5;
	localparam logic [5:0] OP_MOVIIMM    = 6'd6;
	localparam logic [5:0] OP_BSR        = 6'd7;
	localparam logic [5:0] OP_MOVGBRDISP = 6'd8;
	localparam logic [5:0] OP_MOVA       = 6'd9;
	localparam logic [5:0] OP_TSTI       = 6'd10;
	localparam logic [5:0] OP_ANDI       = 6'd11;
	localparam logic [5:0] OP_XORI       = 6'd12;
	localparam logic [5:0] OP_ORI        = 6'd13;
	localparam logic [5:0] OP_TSTB       = 6'd14;
	localparam logic [5:0] OP_ANDB       = 6'd15;
	localparam logic [5:0] OP_XORB       = 6'd16;
	localparam logic [5:0] OP_ORB        = 6'd17;
	localparam logic [5:0] OP_DIV0S      = 6'd18;
	localparam logic [5:0] OP_DIV1       = 6'd19;
	localparam logic [5:0] OP_NEG        = 6'd20;
	localparam logic [5:0] OP_NEGC       = 6'd21;
	localparam logic [5:0] OP_SUB        = 6'd22;
	localparam logic [5:0] OP_SUBC       = 6'd23;
	localparam logic [5:0] OP_ADD        = 6'd24;
	localparam logic [5:0] OP_ADDC       = 6'd25;
	localparam logic [5:0] OP_ADDV       = 6'd26;
	localparam logic [5:0] OP_AND        = 6'd27;
	localparam logic [5:0] OP_XOR        = 6'd28;
	localparam logic [5:0] OP_OR         = 6'd29;
	localparam logic [5:0] OP_MOV        = 6'd30;
	localparam logic [5:0] OP_TST        = 6'd31;
	localparam logic [5:0] OP_MULXW      = 6'd32;
	localparam logic [5:0] OP_EXTU       = 6'd33;
	localparam logic [5:0] OP_EXTS       = 6'd34;
	localparam logic [5:0] OP_SWAPB      = 6'd35;
	localparam logic [5:0] OP_SWAPW      = 6'd36;
	localparam logic [5:0] OP_XTRCT      = 6'd37;
	localparam logic [5:0] OP_MOVT       = 6'd38;
	localparam logic [5:0] OP_STC        = 6'd39;
	localparam logic [5:0] OP_SHLL       = 6'd40;
	localparam logic [5:0] OP_SHLLN      = 6'd41;
	localparam logic [5:0] OP_SHLR       = 6'd42;
	localparam logic [5:0] OP_SHLRN      = 6'd43;
	localparam logic [5:0] OP_SHAR       = 6'd44;
	localparam logic [5:0] OP_ROTL       = 6'd45;
	localparam logic [5:0] OP_ROTR       = 6'd46;
	localparam logic [5:0] OP_ROTCL      = 6'd47;
	localparam logic [5:0] OP_ROTCR      = 6'd48;
	localparam logic [5:0] OP_LDC        = 6'd49;
	localparam logic [5:0] OP_JSR        = 6'd50;
	localparam logic [5:0] OP_STS        = 6'd51;
	localparam logic [5:0] OP_LDS        = 6'd52;
	localparam logic [5:0] OP_JMP        = 6'd53;
	localparam logic [5:0] OP_CLRT       = 6'd54;
	localparam logic [5:0] OP_NOP        = 6'd55;
	localparam logic [5:0] OP_RTS        = 6'd56;
	localparam logic [5:0] OP_DIV0U      = 6'd57;
	localparam logic [5:0] OP_COUNT      = 6'd58;

	// Access sizes.
	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_WORD = 2'd1;
	localparam logic [1:0] SZ_LONG = 2'd2;

	// Addressing modes.
	localparam logic [2:0] MODE_DIRECT  = 3'd0;
	localparam logic [2:0] MODE_IND     = 3'd1;
	localparam logic [2:0] MODE_IDX     = 3'd2;
	localparam logic [2:0] MODE_PREDEC  = 3'd3;
	localparam logic [2:0] MODE_POSTINC = 3'd4;

	// Compare conditions.
	localparam logic [3:0] CC_EQIMM = 4'd0;
	localparam logic [3:0] CC_EQ    = 4'd1;
	localparam logic [3:0] CC_GE    = 4'd2;
	localparam logic [3:0] CC_GT    = 4'd3;
	localparam logic [3:0] CC_HI    = 4'd4;
	localparam logic [3:0] CC_HS    = 4'd5;
	localparam logic [3:0] CC_STR   = 4'd6;
	localparam logic [3:0] CC_PL    = 4'd7;
	localparam logic [3:0] CC_PZ    = 4'd8;

	typedef struct packed {
		logic [5:0] operation;
		logic [1:0] access_size;
		logic       variant_flag;
		logic [2:0] source_mode;
		logic [2:0] dest_mode;
		logic [3:0] compare_cond;
		logic [1:0] special_reg;
		logic [4:0] shift_count;
		logic       illegal;
	} decode_t;

	// Classifies one instruction word. The four mask groups are tried in
	// priority order; the first one that hits supplies the whole result.
	function automatic decode_t decode_word(input logic [15:0] w);
		decode_t    d;
		logic       hit;
		logic [3:0] top;
		logic [3:0] sub;
		logic [3:0] lo;
		logic [1:0] r;
		top = w[15:12];
		sub = w[11:8];
		lo  = w[3:0];
		r   = w[5:4];

		// Top nibble, with the second nibble for the 0x8 and 0xc rows.
		d   = '0;
		hit = 1'b1;
		case (top)
			4'h7: d.operation = OP_ADDI;
			4'h1: begin
				d.operation = OP_MOVREGDISP; d.access_size = SZ_LONG;
			end
			4'h5: begin
				d.operation = OP_MOVREGDISP; d.access_size = SZ_LONG;
				d.variant_flag = 1'b1;
			end
			4'h9: begin
				d.operation = OP_MOVI; d.access_size = SZ_WORD;
			end
			4'ha: d.operation = OP_BRA;
			4'hd: begin
				d.operation = OP_MOVI; d.access_size = SZ_LONG;
			end
			4'he: d.operation = OP_MOVIIMM;
			4'hb: d.operation = OP_BSR;
			4'h8: begin
				case (sub)
					4'h0: d.operation = OP_MOVREGDISP;
					4'h1: begin
						d.operation = OP_MOVREGDISP; d.access_size = SZ_WORD;
					end
					4'h4: begin
						d.operation = OP_MOVREGDISP; d.variant_flag = 1'b1;
					end
					4'h5: begin
						d.operation = OP_MOVREGDISP; d.access_size = SZ_WORD;
						d.variant_flag = 1'b1;
					end
					4'h8: begin
						d.operation = OP_CMP; d.compare_cond = CC_EQIMM;
					end
					4'h9: begin
						d.operation = OP_BT; d.variant_flag = 1'b1;
					end
					4'hb: d.operation = OP_BT;
					default: hit = 1'b0;
				endcase
			end
			4'hc: begin
				if (sub[3]) begin
					d.operation = OP_TSTI + {3'b000, sub[2:0]};
				end else if (sub == 4'h7) begin
					d.operation = OP_MOVA;
				end else if (sub == 4'h3) begin
					hit = 1'b0;
				end else begin
					// Sizes repeat in both halves; the upper half loads.
					d.operation    = OP_MOVGBRDISP;
					d.access_size  = sub[1:0];
					d.variant_flag = sub[2];
				end
			end
			default: hit = 1'b0;
		endcase

		// Top nibble with low nibble.
		if (!hit) begin
			d   = '0;
			hit = 1'b1;
			case ({top, lo})
				8'h30: begin d.operation = OP_CMP; d.compare_cond = CC_EQ;  end
				8'h33: begin d.operation = OP_CMP; d.compare_cond = CC_GE;  end
				8'h37: begin d.operation = OP_CMP; d.compare_cond = CC_GT;  end
				8'h36: begin d.operation = OP_CMP; d.compare_cond = CC_HI;  end
				8'h32: begin d.operation = OP_CMP; d.compare_cond = CC_HS;  end
				8'h2c: begin d.operation = OP_CMP; d.compare_cond = CC_STR; end
				8'h27: d.operation = OP_DIV0S;
				8'h34: d.operation = OP_DIV1;
				8'h6b: d.operation = OP_NEG;
				8'h6a: d.operation = OP_NEGC;
				8'h38: d.operation = OP_SUB;
				8'h3a: d.operation = OP_SUBC;
				8'h3c: d.operation = OP_ADD;
				8'h3e: d.operation = OP_ADDC;
				8'h3f: d.operation = OP_ADDV;
				8'h29: d.operation = OP_AND;
				8'h2a: d.operation = OP_XOR;
				8'h2b: d.operation = OP_OR;
				8'h63: begin d.operation = OP_MOV; d.access_size = SZ_LONG; end
				8'h20, 8'h21, 8'h22: begin
					d.operation = OP_MOV; d.access_size = lo[1:0];
					d.dest_mode = MODE_IND;
				end
				8'h28: d.operation = OP_TST;
				8'h60, 8'h61, 8'h62: begin
					d.operation = OP_MOV; d.access_size = lo[1:0];
					d.source_mode = MODE_IND;
				end
				8'h04, 8'h05, 8'h06: begin
					d.operation = OP_MOV; d.access_size = lo[1:0];
					d.dest_mode = MODE_IDX;
				end
				8'h0c, 8'h0d, 8'h0e: begin
					d.operation = OP_MOV; d.access_size = lo[1:0];
					d.source_mode = MODE_IDX;
				end
				8'h2e: d.operation = OP_MULXW;
				8'h2f: begin d.operation = OP_MULXW; d.variant_flag = 1'b1; end
				8'h6c: d.operation = OP_EXTU;
				8'h6d: begin d.operation = OP_EXTU; d.access_size = SZ_WORD; end
				8'h6e: d.operation = OP_EXTS;
				8'h6f: begin d.operation = OP_EXTS; d.access_size = SZ_WORD; end
				8'h24, 8'h25, 8'h26: begin
					d.operation = OP_MOV; d.access_size = lo[1:0];
					d.dest_mode = MODE_PREDEC;
				end
				8'h64, 8'h65, 8'h66: begin
					d.operation = OP_MOV; d.access_size = lo[1:0];
					d.source_mode = MODE_POSTINC;
				end
				8'h68: d.operation = OP_SWAPB;
				8'h69: d.operation = OP_SWAPW;
				8'h2d: d.operation = OP_XTRCT;
				default: hit = 1'b0;
			endcase
		end

		// Top nibble with low byte.
		if (!hit) begin
			d   = '0;
			hit = 1'b1;
			case ({top, w[7:0]})
				12'h029: d.operation = OP_MOVT;
				12'h002, 12'h012, 12'h022: begin
					d.operation = OP_STC; d.special_reg = r;
				end
				12'h403, 12'h413, 12'h423: begin
					d.operation = OP_STC; d.dest_mode = MODE_PREDEC; d.special_reg = r;
				end
				12'h415: begin d.operation = OP_CMP; d.compare_cond = CC_PL; end
				12'h411: begin d.operation = OP_CMP; d.compare_cond = CC_PZ; end
				12'h400: begin d.operation = OP_SHLL;  d.shift_count = 5'd1;  end
				12'h408: begin d.operation = OP_SHLLN; d.shift_count = 5'd2;  end
				12'h418: begin d.operation = OP_SHLLN; d.shift_count = 5'd8;  end
				12'h428: begin d.operation = OP_SHLLN; d.shift_count = 5'd16; end
				12'h401: begin d.operation = OP_SHLR;  d.shift_count = 5'd1;  end
				12'h409: begin d.operation = OP_SHLRN; d.shift_count = 5'd2;  end
				12'h419: begin d.operation = OP_SHLRN; d.shift_count = 5'd8;  end
				12'h429: begin d.operation = OP_SHLRN; d.shift_count = 5'd16; end
				12'h421: begin d.operation = OP_SHAR;  d.shift_count = 5'd1;  end
				12'h404: d.operation = OP_ROTL;
				12'h405: d.operation = OP_ROTR;
				12'h424: d.operation = OP_ROTCL;
				12'h425: d.operation = OP_ROTCR;
				12'h40e, 12'h41e, 12'h42e: begin
					d.operation = OP_LDC; d.special_reg = r;
				end
				12'h407, 12'h417, 12'h427: begin
					d.operation = OP_LDC; d.source_mode = MODE_POSTINC; d.special_reg = r;
				end
				12'h40b: d.operation = OP_JSR;
				12'h00a, 12'h01a, 12'h02a: begin
					d.operation = OP_STS; d.special_reg = r;
				end
				12'h402, 12'h412, 12'h422: begin
					d.operation = OP_STS; d.dest_mode = MODE_PREDEC; d.special_reg = r;
				end
				12'h40a, 12'h41a, 12'h42a: begin
					d.operation = OP_LDS; d.special_reg = r;
				end
				12'h406, 12'h416, 12'h426: begin
					d.operation = OP_LDS; d.source_mode = MODE_POSTINC; d.special_reg = r;
				end
				12'h42b: d.operation = OP_JMP;
				default: hit = 1'b0;
			endcase
		end

		// Exact word.
		if (!hit) begin
			d   = '0;
			hit = 1'b1;
			case (w)
				16'h0008: d.operation = OP_CLRT;
				16'h0009: d.operation = OP_NOP;
				16'h000b: d.operation = OP_RTS;
				16'h0019: d.operation = OP_DIV0U;
				default:  hit = 1'b0;
			endcase
		end

		if (!hit) begin
			d         = '0;
			d.illegal = 1'b1;
		end
		return d;
	endfunction

endpackage

### hdl/fixed16_opcode_decoder_core.sv
// ----------------------------------------------------------------------------
// fixed16_opcode_decoder_core
// Two-stage decoder that classifies one 16-bit instruction word per cycle unless stalled.
// ----------------------------------------------------------------------------
// The block takes one instruction word per item and returns one result item
// holding the operation family and its qualifiers (size, flag, addressing
// modes, compare condition, special register, shift count) or the illegal
// flag when no pattern matches. It sustains one item per clock cycle while
// out_ready stays high: the word is captured in an input register, decoded
// by a single pass of table logic, and the result lands in an output
// register, where it is offered until out_ready takes it. The input stage
// also advances when it is empty, so a result that waits on out_ready
// does not stop the next word from entering while the input stage has room.
// The block keeps no state besides the pipeline, and reset only clears the
// valid bits.
// ----------------------------------------------------------------------------
module fixed16_opcode_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] opcode_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  operation,
	output logic [1:0]  access_size,
	output logic        variant_flag,
	output logic [2:0]  source_mode,
	output logic [2:0]  dest_mode,
	output logic [3:0]  compare_cond,
	output logic [1:0]  special_reg,
	output logic [4:0]  shift_count,
	output logic        illegal
);

	logic              valid_s1;
	logic [15:0]       word_s1;
	logic              valid_s2;
	f16od_pkg::decode_t res_s2;
	f16od_pkg::decode_t res_comb;
	logic              adv_s2;
	logic              adv_s1;

	// The result stage can take a new item when it is empty or its item
	// leaves this cycle; the input stage likewise when it can hand its item on.
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// The whole classification is one pass of table logic on the held word.
	assign res_comb = f16od_pkg::decode_word(word_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers load only when their stage advances with an item.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1 <= opcode_word;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid    = valid_s2;
	assign operation    = res_s2.operation;
	assign access_size  = res_s2.access_size;
	assign variant_flag = res_s2.variant_flag;
	assign source_mode  = res_s2.source_mode;
	assign dest_mode    = res_s2.dest_mode;
	assign compare_cond = res_s2.compare_cond;
	assign special_reg  = res_s2.special_reg;
	assign shift_count  = res_s2.shift_count;
	assign illegal      = res_s2.illegal;

endmodule

### hdl/f16od_checker.sv
// ----------------------------------------------------------------------------
// f16od_checker
// Port-level checks for the opcode decoder, bound to the top level.
// ----------------------------------------------------------------------------
module f16od_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [15:0] opcode_word,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  operation,
	input logic [1:0]  access_size,
	input logic        variant_flag,
	input logic [2:0]  source_mode,
	input logic [2:0]  dest_mode,
	input logic [3:0]  compare_cond,
	input logic [1:0]  special_reg,
	input logic [4:0]  shift_count,
	input logic        illegal
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(operation)
			&& $stable(illegal) && $stable(access_size) && $stable(shift_count))
		else $error("result changed while stalled");

	// An unmatched word reports nothing but the illegal flag.
	a_illegal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && illegal |-> operation == 6'd0 && access_size == 2'd0
			&& !variant_flag && source_mode == 3'd0 && dest_mode == 3'd0
			&& compare_cond == 4'd0 && special_reg == 2'd0 && shift_count == 5'd0)
		else $error("illegal result carries qualifiers");

	// A legal result names a known family.
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !illegal |-> operation < f16od_pkg::OP_COUNT)
		else $error("operation out of range");

	// Only the fixed shifts carry a shift count.
	a_shift_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shift_count != 5'd0 |->
			operation == f16od_pkg::OP_SHLL || operation == f16od_pkg::OP_SHLLN
			|| operation == f16od_pkg::OP_SHLR || operation == f16od_pkg::OP_SHLRN
			|| operation == f16od_pkg::OP_SHAR)
		else $error("shift count on a non-shift family");

	// An item accepted while the output side stays ready moves from the input
	// register to the output register without waiting and is then offered with out_valid high.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
		else $error("accepted item did not reach the output");

endmodule

bind fixed16_opcode_decoder_core f16od_checker u_f16od_checker (.*);

### tb/sv/tb_fixed16_opcode_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_fixed16_opcode_decoder_core
// Self-checking bench for the 16-bit instruction word classifier.
// ----------------------------------------------------------------------------
// Every word the block accepts is classified again by a behavioral decoder in
// this bench. The result goes into a queue, and each result item the block
// hands out is checked field by field against the oldest queued entry.
// Stimulus is a short directed list followed by words built from the
// instruction patterns with random don't-care bits, single-bit near misses
// and fully random words. Both handshakes idle at random, the receiver once
// holds off long enough to back the block up, and the sender once pauses
// until every result is back.
// ----------------------------------------------------------------------------
module tb_fixed16_opcode_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_STALL_CYCLES = 300;
	localparam int RANDOM_BATCH      = 1000;
	localparam int MAX_REPORTS       = 10;

	// How a side spaces its items: never idle, idle for a uniformly drawn gap,
	// mostly back to back with an occasional long gap, or only short gaps.
	typedef enum int {PACE_FULL, PACE_SPARSE, PACE_BURSTY, PACE_SHORT} pace_t;

	// A queued expectation keeps its word so that a mismatch can name it.
	typedef struct {
		logic [15:0]        word;
		f16od_pkg::decode_t fields;
	} word_decode_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [15:0] opcode_word = 16'h0000;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [5:0]  operation;
	logic [1:0]  access_size;
	logic        variant_flag;
	logic [2:0]  source_mode;
	logic [2:0]  dest_mode;
	logic [3:0]  compare_cond;
	logic [1:0]  special_reg;
	logic [4:0]  shift_count;
	logic        illegal;

	logic [15:0]  queued_words [$];
	word_decode_t expected_decodes [$];
	logic [31:0]  opcode_templates [$];

	bit    word_taken     = 1'b0;
	bit    result_taken   = 1'b0;
	bit    drain_req      = 1'b0;
	bit    long_stall_req = 1'b0;
	int    send_wait      = 0;
	int    stall_left     = 0;
	int    mismatch_count = 0;
	pace_t send_pace      = PACE_FULL;
	pace_t recv_pace      = PACE_FULL;

	fixed16_opcode_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode_word  (opcode_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.operation    (operation),
		.access_size  (access_size),
		.variant_flag (variant_flag),
		.source_mode  (source_mode),
		.dest_mode    (dest_mode),
		.compare_cond (compare_cond),
		.special_reg  (special_reg),
		.shift_count  (shift_count),
		.illegal      (illegal)
	);

	always #4 clk = ~clk;

	// Builds a legal classification; the illegal flag is always clear here.
	function automatic f16od_pkg::decode_t classify_as(input logic [5:0] op,
			input logic [1:0] size, input logic flag, input logic [2:0] src,
			input logic [2:0] dst, input logic [3:0] cond, input logic [1:0] sreg,
			input logic [4:0] sh);
		f16od_pkg::decode_t d;
		d.operation    = op;
		d.access_size  = size;
		d.variant_flag = flag;
		d.source_mode  = src;
		d.dest_mode    = dst;
		d.compare_cond = cond;
		d.special_reg  = sreg;
		d.shift_count  = sh;
		d.illegal      = 1'b0;
		return d;
	endfunction

	// Behavioral decoder. The groups are tried in priority order: top byte
	// (whole top-nibble rows included), top and low nibble, top nibble with
	// the low byte, and finally the exact word.
	function automatic f16od_pkg::decode_t predict_decode(input logic [15:0] w);
		f16od_pkg::decode_t d;
		logic               found;
		logic [3:0]         sub;
		logic [15:0]        nib_key;
		logic [15:0]        byte_key;
		logic [1:0]         sreg;
		sub      = w[11:8];
		nib_key  = w & 16'hf00f;
		byte_key = w & 16'hf0ff;
		sreg     = byte_key[5:4];
		d        = '0;
		found    = 1'b1;

		case (w[15:12])
			4'h7: d = classify_as(f16od_pkg::OP_ADDI, f16od_pkg::SZ_BYTE, 0, 0, 0, 0, 0, 0);
			4'h1: d = classify_as(f16od_pkg::OP_MOVREGDISP, f16od_pkg::SZ_LONG,
				0, 0, 0, 0, 0, 0);
			4'h5: d = classify_as(f16od_pkg::OP_MOVREGDISP, f16od_pkg::SZ_LONG,
				1, 0, 0, 0, 0, 0);
			4'h9: d = classify_as(f16od_pkg::OP_MOVI, f16od_pkg::SZ_WORD, 0, 0, 0, 0, 0, 0);
			4'ha: d = classify_as(f16od_pkg::OP_BRA, f16od_pkg::SZ_BYTE, 0, 0, 0, 0, 0, 0);
			4'hd: d = classify_as(f16od_pkg::OP_MOVI, f16od_pkg::SZ_LONG, 0, 0, 0, 0, 0, 0);
			4'he: d = classify_as(f16od_pkg::OP_MOVIIMM, f16od_pkg::SZ_BYTE,
				0, 0, 0, 0, 0, 0);
			4'hb: d = classify_as(f16od_pkg::OP_BSR, f16od_pkg::SZ_BYTE, 0, 0, 0, 0, 0, 0);
			4'h8: begin
				case (sub)
					4'h0: d = classify_as(f16od_pkg::OP_MOVREGDISP, f16od_pkg::SZ_BYTE,
						0, 0, 0, 0, 0, 0);
					4'h1: d = classify_as(f16od_pkg::OP_MOVREGDISP, f16od_pkg::SZ_WORD,
						0, 0, 0, 0, 0, 0);
					4'h4: d = classify_as(f16od_pkg::OP_MOVREGDISP, f16od_pkg::SZ_BYTE,
						1, 0, 0, 0, 0, 0);
					4'h5: d = classify_as(f16od_pkg::OP_MOVREGDISP, f16od_pkg::SZ_WORD,
						1, 0, 0, 0, 0, 0);
					4'h8: d = classify_as(f16od_pkg::OP_CMP, f16od_pkg::SZ_BYTE,
						0, 0, 0, f16od_pkg::CC_EQIMM, 0, 0);
					4'h9: d = classify_as(f16od_pkg::OP_BT, f16od_pkg::SZ_BYTE,
						1, 0, 0, 0, 0, 0);
					4'hb: d = classify_as(f16od_pkg::OP_BT, f16od_pkg::SZ_BYTE,
						0, 0, 0, 0, 0, 0);
					default: found = 1'b0;
				endcase
			end
			4'hc: begin
				if (sub <= 4'd2) begin
					d = classify_as(f16od_pkg::OP_MOVGBRDISP, 2'(sub), 0, 0, 0, 0, 0, 0);
				end else if (sub >= 4'd4 && sub <= 4'd6) begin
					d = classify_as(f16od_pkg::OP_MOVGBRDISP, 2'(sub - 4'd4),
						1, 0, 0, 0, 0, 0);
				end else if (sub == 4'd7) begin
					d = classify_as(f16od_pkg::OP_MOVA, f16od_pkg::SZ_BYTE, 0, 0, 0, 0, 0, 0);
				end else if (sub >= 4'd8) begin
					d = classify_as(f16od_pkg::OP_TSTI + 6'(sub) - 6'd8, f16od_pkg::SZ_BYTE,
						0, 0, 0, 0, 0, 0);
				end else begin
					found = 1'b0;
				end
			end
			default: found = 1'b0;
		endcase

		if (!found) begin
			found = 1'b1;
			case (nib_key)
				16'h3000: d = classify_as(f16od_pkg::OP_CMP, 0, 0, 0, 0,
					f16od_pkg::CC_EQ, 0, 0);
				16'h3003: d = classify_as(f16od_pkg::OP_CMP, 0, 0, 0, 0,
					f16od_pkg::CC_GE, 0, 0);
				16'h3007: d = classify_as(f16od_pkg::OP_CMP, 0, 0, 0, 0,
					f16od_pkg::CC_GT, 0, 0);
				16'h3006: d = classify_as(f16od_pkg::OP_CMP, 0, 0, 0, 0,
					f16od_pkg::CC_HI, 0, 0);
				16'h3002: d = classify_as(f16od_pkg::OP_CMP, 0, 0, 0, 0,
					f16od_pkg::CC_HS, 0, 0);
				16'h200c: d = classify_as(f16od_pkg::OP_CMP, 0, 0, 0, 0,
					f16od_pkg::CC_STR, 0, 0);
				16'h2007: d = classify_as(f16od_pkg::OP_DIV0S, 0, 0, 0, 0, 0, 0, 0);
				16'h3004: d = classify_as(f16od_pkg::OP_DIV1, 0, 0, 0, 0, 0, 0, 0);
				16'h600b: d = classify_as(f16od_pkg::OP_NEG, 0, 0, 0, 0, 0, 0, 0);
				16'h600a: d = classify_as(f16od_pkg::OP_NEGC, 0, 0, 0, 0, 0, 0, 0);
				16'h3008: d = classify_as(f16od_pkg::OP_SUB, 0, 0, 0, 0, 0, 0, 0);
				16'h300a: d = classify_as(f16od_pkg::OP_SUBC, 0, 0, 0, 0, 0, 0, 0);
				16'h300c: d = classify_as(f16od_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0);
				16'h300e: d = classify_as(f16od_pkg::OP_ADDC, 0, 0, 0, 0, 0, 0, 0);
				16'h300f: d = classify_as(f16od_pkg::OP_ADDV, 0, 0, 0, 0, 0, 0, 0);
				16'h2009: d = classify_as(f16od_pkg::OP_AND, 0, 0, 0, 0, 0, 0, 0);
				16'h200a: d = classify_as(f16od_pkg::OP_XOR, 0, 0, 0, 0, 0, 0, 0);
				16'h200b: d = classify_as(f16od_pkg::OP_OR, 0, 0, 0, 0, 0, 0, 0);
				16'h6003: d = classify_as(f16od_pkg::OP_MOV, f16od_pkg::SZ_LONG,
					0, 0, 0, 0, 0, 0);
				16'h2000, 16'h2001, 16'h2002:
					d = classify_as(f16od_pkg::OP_MOV, w[1:0], 0, f16od_pkg::MODE_DIRECT,
						f16od_pkg::MODE_IND, 0, 0, 0);
				16'h2008: d = classify_as(f16od_pkg::OP_TST, 0, 0, 0, 0, 0, 0, 0);
				16'h6000, 16'h6001, 16'h6002:
					d = classify_as(f16od_pkg::OP_MOV, w[1:0], 0, f16od_pkg::MODE_IND,
						f16od_pkg::MODE_DIRECT, 0, 0, 0);
				16'h0004, 16'h0005, 16'h0006:
					d = classify_as(f16od_pkg::OP_MOV, 2'(w[3:0] - 4'h4), 0,
						f16od_pkg::MODE_DIRECT, f16od_pkg::MODE_IDX, 0, 0, 0);
				16'h000c, 16'h000d, 16'h000e:
					d = classify_as(f16od_pkg::OP_MOV, 2'(w[3:0] - 4'hc), 0,
						f16od_pkg::MODE_IDX, f16od_pkg::MODE_DIRECT, 0, 0, 0);
				16'h200e: d = classify_as(f16od_pkg::OP_MULXW, 0, 0, 0, 0, 0, 0, 0);
				16'h200f: d = classify_as(f16od_pkg::OP_MULXW, 0, 1, 0, 0, 0, 0, 0);
				16'h600c: d = classify_as(f16od_pkg::OP_EXTU, f16od_pkg::SZ_BYTE,
					0, 0, 0, 0, 0, 0);
				16'h600d: d = classify_as(f16od_pkg::OP_EXTU, f16od_pkg::SZ_WORD,
					0, 0, 0, 0, 0, 0);
				16'h600e: d = classify_as(f16od_pkg::OP_EXTS, f16od_pkg::SZ_BYTE,
					0, 0, 0, 0, 0, 0);
				16'h600f: d = classify_as(f16od_pkg::OP_EXTS, f16od_pkg::SZ_WORD,
					0, 0, 0, 0, 0, 0);
				16'h2004, 16'h2005, 16'h2006:
					d = classify_as(f16od_pkg::OP_MOV, 2'(w[3:0] - 4'h4), 0,
						f16od_pkg::MODE_DIRECT, f16od_pkg::MODE_PREDEC, 0, 0, 0);
				16'h6004, 16'h6005, 16'h6006:
					d = classify_as(f16od_pkg::OP_MOV, 2'(w[3:0] - 4'h4), 0,
						f16od_pkg::MODE_POSTINC, f16od_pkg::MODE_DIRECT, 0, 0, 0);
				16'h6008: d = classify_as(f16od_pkg::OP_SWAPB, 0, 0, 0, 0, 0, 0, 0);
				16'h6009: d = classify_as(f16od_pkg::OP_SWAPW, 0, 0, 0, 0, 0, 0, 0);
				16'h200d: d = classify_as(f16od_pkg::OP_XTRCT, 0, 0, 0, 0, 0, 0, 0);
				default: found = 1'b0;
			endcase
		end

		if (!found) begin
			found = 1'b1;
			case (byte_key)
				16'h0029: d = classify_as(f16od_pkg::OP_MOVT, 0, 0, 0, 0, 0, 0, 0);
				16'h0002, 16'h0012, 16'h0022:
					d = classify_as(f16od_pkg::OP_STC, 0, 0, 0, f16od_pkg::MODE_DIRECT,
						0, sreg, 0);
				16'h4003, 16'h4013, 16'h4023:
					d = classify_as(f16od_pkg::OP_STC, 0, 0, 0, f16od_pkg::MODE_PREDEC,
						0, sreg, 0);
				16'h4015: d = classify_as(f16od_pkg::OP_CMP, 0, 0, 0, 0,
					f16od_pkg::CC_PL, 0, 0);
				16'h4011: d = classify_as(f16od_pkg::OP_CMP, 0, 0, 0, 0,
					f16od_pkg::CC_PZ, 0, 0);
				16'h4000: d = classify_as(f16od_pkg::OP_SHLL, 0, 0, 0, 0, 0, 0, 5'd1);
				16'h4008: d = classify_as(f16od_pkg::OP_SHLLN, 0, 0, 0, 0, 0, 0, 5'd2);
				16'h4018: d = classify_as(f16od_pkg::OP_SHLLN, 0, 0, 0, 0, 0, 0, 5'd8);
				16'h4028: d = classify_as(f16od_pkg::OP_SHLLN, 0, 0, 0, 0, 0, 0, 5'd16);
				16'h4001: d = classify_as(f16od_pkg::OP_SHLR, 0, 0, 0, 0, 0, 0, 5'd1);
				16'h4009: d = classify_as(f16od_pkg::OP_SHLRN, 0, 0, 0, 0, 0, 0, 5'd2);
				16'h4019: d = classify_as(f16od_pkg::OP_SHLRN, 0, 0, 0, 0, 0, 0, 5'd8);
				16'h4029: d = classify_as(f16od_pkg::OP_SHLRN, 0, 0, 0, 0, 0, 0, 5'd16);
				16'h4021: d = classify_as(f16od_pkg::OP_SHAR, 0, 0, 0, 0, 0, 0, 5'd1);
				16'h4004: d = classify_as(f16od_pkg::OP_ROTL, 0, 0, 0, 0, 0, 0, 0);
				16'h4005: d = classify_as(f16od_pkg::OP_ROTR, 0, 0, 0, 0, 0, 0, 0);
				16'h4024: d = classify_as(f16od_pkg::OP_ROTCL, 0, 0, 0, 0, 0, 0, 0);
				16'h4025: d = classify_as(f16od_pkg::OP_ROTCR, 0, 0, 0, 0, 0, 0, 0);
				16'h400e, 16'h401e, 16'h402e:
					d = classify_as(f16od_pkg::OP_LDC, 0, 0, f16od_pkg::MODE_DIRECT, 0,
						0, sreg, 0);
				16'h4007, 16'h4017, 16'h4027:
					d = classify_as(f16od_pkg::OP_LDC, 0, 0, f16od_pkg::MODE_POSTINC, 0,
						0, sreg, 0);
				16'h400b: d = classify_as(f16od_pkg::OP_JSR, 0, 0, 0, 0, 0, 0, 0);
				16'h000a, 16'h001a, 16'h002a:
					d = classify_as(f16od_pkg::OP_STS, 0, 0, 0, f16od_pkg::MODE_DIRECT,
						0, sreg, 0);
				16'h4002, 16'h4012, 16'h4022:
					d = classify_as(f16od_pkg::OP_STS, 0, 0, 0, f16od_pkg::MODE_PREDEC,
						0, sreg, 0);
				16'h400a, 16'h401a, 16'h402a:
					d = classify_as(f16od_pkg::OP_LDS, 0, 0, f16od_pkg::MODE_DIRECT, 0,
						0, sreg, 0);
				16'h4006, 16'h4016, 16'h4026:
					d = classify_as(f16od_pkg::OP_LDS, 0, 0, f16od_pkg::MODE_POSTINC, 0,
						0, sreg, 0);
				16'h402b: d = classify_as(f16od_pkg::OP_JMP, 0, 0, 0, 0, 0, 0, 0);
				default: found = 1'b0;
			endcase
		end

		if (!found) begin
			found = 1'b1;
			case (w)
				16'h0008: d = classify_as(f16od_pkg::OP_CLRT, 0, 0, 0, 0, 0, 0, 0);
				16'h0009: d = classify_as(f16od_pkg::OP_NOP, 0, 0, 0, 0, 0, 0, 0);
				16'h000b: d = classify_as(f16od_pkg::OP_RTS, 0, 0, 0, 0, 0, 0, 0);
				16'h0019: d = classify_as(f16od_pkg::OP_DIV0U, 0, 0, 0, 0, 0, 0, 0);
				default: found = 1'b0;
			endcase
		end

		// Nothing matched: only the illegal flag is set.
		if (!found) begin
			d         = '0;
			d.illegal = 1'b1;
		end
		return d;
	endfunction

	// One line of text with every field of a result.
	function automatic string fields_text(input f16od_pkg::decode_t d);
		return $sformatf("op=%0d sz=%0d flag=%0b src=%0d dst=%0d cc=%0d sr=%0d sh=%0d ill=%0b",
			d.operation, d.access_size, d.variant_flag, d.source_mode, d.dest_mode,
			d.compare_cond, d.special_reg, d.shift_count, d.illegal);
	endfunction

	// Idle cycles before the next item, according to the current pace.
	function automatic int draw_gap(input pace_t pace);
		case (pace)
			PACE_FULL:   return 0;
			PACE_SPARSE: return $urandom_range(0, 18);
			PACE_BURSTY: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
			default:     return $urandom_range(0, 2);
		endcase
	endfunction

	// Most words follow one of the instruction patterns with random bits in
	// the don't-care positions, which keeps every group and every operation
	// busy. The rest are single-bit near misses of a pattern or raw noise.
	function automatic logic [15:0] random_word();
		logic [31:0] pick;
		logic [15:0] w;
		int          roll;
		roll = $urandom_range(0, 99);
		pick = opcode_templates[$urandom_range(0, opcode_templates.size() - 1)];
		w    = (16'($urandom) & ~pick[31:16]) | pick[15:0];
		if (roll < 15) begin
			w = 16'($urandom);
		end else if (roll < 25) begin
			w = w ^ (16'h0001 << $urandom_range(0, 15));
		end
		return w;
	endfunction

	// Samples both handshakes at the rising edge. An accepted word is
	// classified right away; an accepted result is checked against the oldest
	// classification still waiting.
	always @(posedge clk) begin
		word_decode_t       want;
		f16od_pkg::decode_t got;
		word_taken   = in_valid && in_ready;
		result_taken = out_valid && out_ready;
		if (arst_n) begin
			if (word_taken) begin
				want.word   = opcode_word;
				want.fields = predict_decode(opcode_word);
				expected_decodes.push_back(want);
			end
			if (result_taken) begin
				got.operation    = operation;
				got.access_size  = access_size;
				got.variant_flag = variant_flag;
				got.source_mode  = source_mode;
				got.dest_mode    = dest_mode;
				got.compare_cond = compare_cond;
				got.special_reg  = special_reg;
				got.shift_count  = shift_count;
				got.illegal      = illegal;
				if (expected_decodes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("[%0t] result item with no word outstanding: %s",
							$realtime, fields_text(got));
					end
				end else begin
					want = expected_decodes.pop_front();
					if (got !== want.fields) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$display("[%0t] word %04h decoded wrong", $realtime, want.word);
							$display("  expected %s", fields_text(want.fields));
							$display("  actual   %s", fields_text(got));
						end
					end
				end
			end
		end
	end

	// Sender. A new word goes out only once the previous one was taken and
	// its gap has run out. Valid is never lowered while an item waits, and
	// a drain request keeps the next word back.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || word_taken) begin
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (!drain_req && queued_words.size() != 0) begin
				opcode_word <= queued_words.pop_front();
				in_valid    <= 1'b1;
				if ($urandom_range(0, 39) == 0) begin
					send_pace = pace_t'($urandom_range(0, 3));
				end
				send_wait = draw_gap(send_pace);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver. After each result item it may hold ready low for a drawn
	// number of cycles. A long stall request overrides that and keeps ready
	// low long enough for both pipeline stages to fill and in_ready to drop.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall_left     = LONG_STALL_CYCLES;
			end else if (result_taken) begin
				if ($urandom_range(0, 39) == 0) begin
					recv_pace = pace_t'($urandom_range(0, 3));
				end
				stall_left = draw_gap(recv_pace);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of test.
	initial begin
		opcode_templates = '{
			// Top-nibble rows; the 0x8 and 0xc rows leave holes that stay illegal.
			32'hf000_7000, 32'hf000_1000, 32'hf000_5000, 32'hf000_9000, 32'hf000_a000,
			32'hf000_d000, 32'hf000_e000, 32'hf000_b000, 32'hf000_8000, 32'hf000_c000,
			// Top nibble with low nibble.
			32'hf00f_3000, 32'hf00f_3003, 32'hf00f_3007, 32'hf00f_3006, 32'hf00f_3002,
			32'hf00f_200c, 32'hf00f_2007, 32'hf00f_3004, 32'hf00f_600b, 32'hf00f_600a,
			32'hf00f_3008, 32'hf00f_300a, 32'hf00f_300c, 32'hf00f_300e, 32'hf00f_300f,
			32'hf00f_2009, 32'hf00f_200a, 32'hf00f_200b, 32'hf00f_6003, 32'hf00f_2000,
			32'hf00f_2001, 32'hf00f_2002, 32'hf00f_2008, 32'hf00f_6000, 32'hf00f_6001,
			32'hf00f_6002, 32'hf00f_0004, 32'hf00f_0005, 32'hf00f_0006, 32'hf00f_000c,
			32'hf00f_000d, 32'hf00f_000e, 32'hf00f_200e, 32'hf00f_200f, 32'hf00f_600c,
			32'hf00f_600d, 32'hf00f_600e, 32'hf00f_600f, 32'hf00f_2004, 32'hf00f_2005,
			32'hf00f_2006, 32'hf00f_6004, 32'hf00f_6005, 32'hf00f_6006, 32'hf00f_6008,
			32'hf00f_6009, 32'hf00f_200d,
			// Top nibble with low byte.
			32'hf0ff_0029, 32'hf0ff_0002, 32'hf0ff_0012, 32'hf0ff_0022, 32'hf0ff_4003,
			32'hf0ff_4013, 32'hf0ff_4023, 32'hf0ff_4015, 32'hf0ff_4011, 32'hf0ff_4000,
			32'hf0ff_4008, 32'hf0ff_4018, 32'hf0ff_4028, 32'hf0ff_4001, 32'hf0ff_4009,
			32'hf0ff_4019, 32'hf0ff_4029, 32'hf0ff_4021, 32'hf0ff_4004, 32'hf0ff_4005,
			32'hf0ff_4024, 32'hf0ff_4025, 32'hf0ff_400e, 32'hf0ff_401e, 32'hf0ff_402e,
			32'hf0ff_4007, 32'hf0ff_4017, 32'hf0ff_4027, 32'hf0ff_400b, 32'hf0ff_000a,
			32'hf0ff_001a, 32'hf0ff_002a, 32'hf0ff_4002, 32'hf0ff_4012, 32'hf0ff_4022,
			32'hf0ff_400a, 32'hf0ff_401a, 32'hf0ff_402a, 32'hf0ff_4006, 32'hf0ff_4016,
			32'hf0ff_4026, 32'hf0ff_402b,
			// Exact words.
			32'hffff_0008, 32'hffff_0009, 32'hffff_000b, 32'hffff_0019
		};

		// Directed words: all-zero and all-one words (both unmatched), the
		// exact-word operations, fixed shift counts up to sixteen, the holes
		// in the 0x8 and 0xc rows, indexed moves at both ends of the size
		// range, special register fields of 2 and of the unused 3, and a word
		// two bits away from an exact match.
		queued_words = '{
			16'h0000, 16'hffff, 16'h7fff, 16'h0008, 16'h0009,
			16'h000b, 16'h0019, 16'h4018, 16'h4028, 16'h4f29,
			16'h402b, 16'h3004, 16'h3ff4, 16'h8800, 16'h8200,
			16'hc300, 16'hcfff, 16'h0ff4, 16'h0f0e, 16'h0022,
			16'h4f27, 16'h0032, 16'h4f15, 16'h6ffb, 16'h0038
		};
		repeat (RANDOM_BATCH) queued_words.push_back(random_word());

		repeat (3) @(posedge clk);
		#1 arst_n = 1'b1;

		// Once traffic is flowing, back the block up with a long receiver
		// stall while the sender keeps offering words.
		while (queued_words.size() > 800) @(posedge clk);
		long_stall_req = 1'b1;

		// Later, let the pipeline run completely dry before resuming.
		while (queued_words.size() > 400) @(posedge clk);
		drain_req = 1'b1;
		while (in_valid || expected_decodes.size() != 0) @(posedge clk);
		drain_req = 1'b0;

		repeat (RANDOM_BATCH) queued_words.push_back(random_word());

		while (queued_words.size() != 0 || in_valid || expected_decodes.size() != 0) begin
			@(posedge clk);
		end
		// Keep the clock running after the last result so that a stray extra result would still be seen.
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && expected_decodes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog, well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

### fixed16_opcode_decoder_core.f
hdl/f16od_pkg.sv
hdl/fixed16_opcode_decoder_core.sv
hdl/f16od_checker.sv
tb/sv/tb_fixed16_opcode_decoder_core.sv
